>>> design/fke_pkg.sv
// ----------------------------------------------------------------------------
// fke_pkg
// Shared types and constants for the IPv4 flow key extractor.
// ----------------------------------------------------------------------------
package fke_pkg;

	localparam logic [6:0] POS_MAX       = 7'd127;
	localparam logic [6:0] HDR_MIN_BYTES = 7'd20;
	localparam logic [3:0] XPORT_MAX     = 4'd8;

	localparam logic [7:0] PROTO_ICMP    = 8'd1;
	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam logic [7:0] PROTO_UDP     = 8'd17;
	localparam logic [7:0] PROTO_DCCP    = 8'd33;
	localparam logic [7:0] PROTO_ESP     = 8'd50;
	localparam logic [7:0] PROTO_AH      = 8'd51;
	localparam logic [7:0] PROTO_IPCOMP  = 8'd108;
	localparam logic [7:0] PROTO_SCTP    = 8'd132;
	localparam logic [7:0] PROTO_UDPLITE = 8'd136;

	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_PORTS,
		CLS_ICMP,
		CLS_ESP,
		CLS_AH,
		CLS_IPCOMP
	} fke_cls_t;

	typedef struct packed {
		fke_cls_t    cls;
		logic [7:0]  proto;
		logic [7:0]  tos;
		logic [31:0] src;
		logic [31:0] dst;
		logic [63:0] xbytes;
		logic [3:0]  xcount;
		logic        frag;
		logic        hdr_short;
	} fke_rec_t;

	function automatic fke_cls_t fke_classify(input logic [7:0] proto, input logic frag);
		fke_cls_t c;
		c = CLS_NONE;
		if (!frag) begin
			case (proto)
				PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_SCTP, PROTO_UDPLITE: c = CLS_PORTS;
				PROTO_ICMP:   c = CLS_ICMP;
				PROTO_ESP:    c = CLS_ESP;
				PROTO_AH:     c = CLS_AH;
				PROTO_IPCOMP: c = CLS_IPCOMP;
				default:      c = CLS_NONE;
			endcase
		end
		return c;
	endfunction

endpackage

>>> design/fke_front.sv
// ----------------------------------------------------------------------------
// fke_front
// Byte intake: captures header fields and transport bytes, classifies the
// packet and pushes one record per packet on the last byte.
// ----------------------------------------------------------------------------
module fke_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              q_full,
	output logic              push,
	output fke_pkg::fke_rec_t rec
);
	import fke_pkg::*;

	logic [6:0]  pos_q, pos_n;
	logic [3:0]  hw_q, hw_n;
	logic        frag_q, frag_n;
	logic [7:0]  proto_q, proto_n;
	logic [7:0]  tos_q, tos_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [63:0] xb_q, xb_n;
	logic [3:0]  xc_q, xc_n;
	logic [6:0]  off, off_end;
	logic        cap;
	logic        acc;

	assign in_stall = q_full;
	assign acc      = in_valid && !in_stall;
	assign push     = acc && last_byte;

	always_comb begin
		hw_n    = hw_q;
		tos_n   = tos_q;
		proto_n = proto_q;
		src_n   = src_q;
		dst_n   = dst_q;
		frag_n  = frag_q;
		xb_n    = xb_q;
		xc_n    = xc_q;
		if (pos_q == 7'd0) begin
			hw_n = data_byte[3:0];
		end
		if (pos_q == 7'd1) begin
			tos_n = data_byte;
		end
		if (pos_q == 7'd6 && data_byte[5:0] != 6'd0) begin
			frag_n = 1'b1;
		end
		if (pos_q == 7'd7 && data_byte != 8'd0) begin
			frag_n = 1'b1;
		end
		if (pos_q == 7'd9) begin
			proto_n = data_byte;
		end
		if (pos_q >= 7'd12 && pos_q < 7'd16) begin
			src_n = {src_q[23:0], data_byte};
		end
		if (pos_q >= 7'd16 && pos_q < 7'd20) begin
			dst_n = {dst_q[23:0], data_byte};
		end
		off     = {1'b0, hw_n, 2'b00};
		off_end = off + 7'd8;
		cap     = (pos_q >= off) && (pos_q < off_end) && (xc_q < XPORT_MAX);
		if (cap) begin
			for (int i = 0; i < 8; i++) begin
				if (xc_q[2:0] == 3'(i)) begin
					xb_n[63 - 8 * i -: 8] = data_byte;
				end
			end
			xc_n = xc_q + 4'd1;
		end
		pos_n = (pos_q < POS_MAX) ? pos_q + 7'd1 : pos_q;
	end

	always_comb begin
		rec.cls       = fke_classify(proto_n, frag_n);
		rec.proto     = proto_n;
		rec.tos       = tos_n;
		rec.src       = src_n;
		rec.dst       = dst_n;
		rec.xbytes    = xb_n;
		rec.xcount    = xc_n;
		rec.frag      = frag_n;
		rec.hdr_short = pos_n < HDR_MIN_BYTES;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hw_q    <= '0;
			frag_q  <= 1'b0;
			proto_q <= '0;
			tos_q   <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			xb_q    <= '0;
			xc_q    <= '0;
		end else if (acc) begin
			if (last_byte) begin
				pos_q   <= '0;
				hw_q    <= '0;
				frag_q  <= 1'b0;
				proto_q <= '0;
				tos_q   <= '0;
				src_q   <= '0;
				dst_q   <= '0;
				xb_q    <= '0;
				xc_q    <= '0;
			end else begin
				pos_q   <= pos_n;
				hw_q    <= hw_n;
				frag_q  <= frag_n;
				proto_q <= proto_n;
				tos_q   <= tos_n;
				src_q   <= src_n;
				dst_q   <= dst_n;
				xb_q    <= xb_n;
				xc_q    <= xc_n;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (pos_q == 7'd0 && xc_q == 4'd0 && xb_q == 64'd0))
		else $error("state not cleared after last byte");

	a_xc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		xc_q <= XPORT_MAX)
		else $error("transport count overrun");

endmodule

>>> design/fke_queue.sv
// ----------------------------------------------------------------------------
// fke_queue
// Two-entry record queue between intake and decode.
// ----------------------------------------------------------------------------
module fke_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fke_pkg::fke_rec_t wr_rec,
	output logic              full,
	output logic              not_empty,
	input  logic              pop,
	output fke_pkg::fke_rec_t rd_rec
);
	import fke_pkg::*;

	fke_rec_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rd_rec    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("pop from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2)
		else $error("queue count out of range");

endmodule

>>> design/fke_back.sv
// ----------------------------------------------------------------------------
// fke_back
// Transport decode by class and registered result output.
// ----------------------------------------------------------------------------
module fke_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_not_empty,
	input  fke_pkg::fke_rec_t rec,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        protocol,
	output logic [31:0]       src_addr,
	output logic [31:0]       dst_addr,
	output logic [7:0]        type_of_service,
	output logic [15:0]       src_port,
	output logic [15:0]       dst_port,
	output logic [7:0]        icmp_kind,
	output logic [7:0]        icmp_subcode,
	output logic [31:0]       security_index,
	output logic              is_fragment,
	output logic              too_short
);
	import fke_pkg::*;

	logic        vld_q;
	logic [7:0]  proto_q, tos_q, ity_q, icode_q;
	logic [31:0] src_q, dst_q, spi_q;
	logic [15:0] sport_q, dport_q;
	logic        frag_q, short_q;

	logic [3:0]  need;
	logic [31:0] hi32, lo32, spi;
	logic [15:0] sport, dport;
	logic [7:0]  ity, icode;
	logic        ok;

	assign pop = q_not_empty && (!vld_q || !out_stall);

	always_comb begin
		hi32  = rec.xbytes[63:32];
		lo32  = rec.xbytes[31:0];
		sport = '0;
		dport = '0;
		ity   = '0;
		icode = '0;
		spi   = '0;
		case (rec.cls)
			CLS_PORTS:  need = 4'd4;
			CLS_ICMP:   need = 4'd2;
			CLS_ESP:    need = 4'd4;
			CLS_AH:     need = 4'd8;
			CLS_IPCOMP: need = 4'd4;
			default:    need = 4'd0;
		endcase
		ok = rec.xcount >= need;
		if (ok) begin
			case (rec.cls)
				CLS_PORTS: begin
					sport = hi32[31:16];
					dport = hi32[15:0];
				end
				CLS_ICMP: begin
					ity   = hi32[31:24];
					icode = hi32[23:16];
				end
				CLS_ESP:    spi = hi32;
				CLS_AH:     spi = lo32;
				CLS_IPCOMP: spi = {16'd0, hi32[15:0]};
				default:    spi = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			proto_q <= rec.proto;
			src_q   <= rec.src;
			dst_q   <= rec.dst;
			tos_q   <= rec.tos;
			sport_q <= sport;
			dport_q <= dport;
			ity_q   <= ity;
			icode_q <= icode;
			spi_q   <= spi;
			frag_q  <= rec.frag;
			short_q <= rec.hdr_short || !ok;
		end
	end

	assign out_valid       = vld_q;
	assign protocol        = proto_q;
	assign src_addr        = src_q;
	assign dst_addr        = dst_q;
	assign type_of_service = tos_q;
	assign src_port        = sport_q;
	assign dst_port        = dport_q;
	assign icmp_kind       = ity_q;
	assign icmp_subcode    = icode_q;
	assign security_index  = spi_q;
	assign is_fragment     = frag_q;
	assign too_short       = short_q;

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> vld_q)
		else $error("popped record not presented");

	a_frag_no_xport: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && frag_q) |-> (sport_q == 16'd0 && dport_q == 16'd0 && spi_q == 32'd0))
		else $error("transport fields on fragment");

endmodule

>>> design/ipv4_flow_key_extract_core.sv
// ----------------------------------------------------------------------------
// ipv4_flow_key_extract_core
// IPv4 five-tuple flow key extraction, one packet byte per transfer.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid, in_stall, data_byte, last_byte  | in
//   out     | out_valid, out_stall, flow key fields     | out
//
// One byte per cycle is taken while the record queue has room.
// After the last byte's transfer the flow key is written to the record queue and
// then loaded into the output register once that register is free.
// A two-entry queue parts intake from decode; in_stall is the queue full flag.
// Reset clears all parse state, the queue pointers and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_flow_key_extract_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  protocol,
	output logic [31:0] src_addr,
	output logic [31:0] dst_addr,
	output logic [7:0]  type_of_service,
	output logic [15:0] src_port,
	output logic [15:0] dst_port,
	output logic [7:0]  icmp_kind,
	output logic [7:0]  icmp_subcode,
	output logic [31:0] security_index,
	output logic        is_fragment,
	output logic        too_short
);
	import fke_pkg::*;

	fke_rec_t wr_rec, rd_rec;
	logic     push, pop, q_full, q_not_empty;

	fke_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.rec       (wr_rec)
	);

	fke_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_rec    (wr_rec),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (pop),
		.rd_rec    (rd_rec)
	);

	fke_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.rec             (rd_rec),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.protocol        (protocol),
		.src_addr        (src_addr),
		.dst_addr        (dst_addr),
		.type_of_service (type_of_service),
		.src_port        (src_port),
		.dst_port        (dst_port),
		.icmp_kind       (icmp_kind),
		.icmp_subcode    (icmp_subcode),
		.security_index  (security_index),
		.is_fragment     (is_fragment),
		.too_short       (too_short)
	);

endmodule

>>> verif/ipv4_flow_key_extract_core_tb.sv
// ----------------------------------------------------------------------------
// ipv4_flow_key_extract_core_tb
// Self-checking bench for the IPv4 flow key extractor. Packets go in one byte
// per transfer; a shadow of the extractor works out each flow key when the
// last byte transfers, and every key leaving the block is compared field by
// field with the oldest one pending. Directed packets cover each protocol,
// fragments, short and long packets and odd header lengths; random traffic
// follows, with gaps and stalls on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module ipv4_flow_key_extract_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fke_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES    = 250;
	localparam int TOTAL_BYTES    = 850;
	localparam int MIN_RAND_PKTS  = 2;

	typedef struct packed {
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [7:0]  type_of_service;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  icmp_kind;
		logic [7:0]  icmp_subcode;
		logic [31:0] security_index;
		logic        is_fragment;
		logic        too_short;
	} flow_key_t;

	typedef struct packed {
		logic [6:0]  pos;
		logic [3:0]  ihl;
		logic        frag;
		logic [7:0]  proto;
		logic [7:0]  tos;
		logic [31:0] src;
		logic [31:0] dst;
		logic [63:0] xbytes;
		logic [3:0]  xcount;
	} parse_state_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  protocol;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [7:0]  type_of_service;
	logic [15:0] src_port;
	logic [15:0] dst_port;
	logic [7:0]  icmp_kind;
	logic [7:0]  icmp_subcode;
	logic [31:0] security_index;
	logic        is_fragment;
	logic        too_short;

	parse_state_t parser;
	flow_key_t    pending_keys[$];
	flow_key_t    got_key;
	logic [7:0]   pkt[$];
	int           errors = 0;
	int           bytes_sent;
	int           pkts_sent;
	int           idle_cycles = 0;
	int           holds_asked;
	int           holds_taken = 0;
	int           hold_left = 0;
	bit           no_gaps;

	ipv4_flow_key_extract_core dut (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Shadow parser: consumes one byte, returns 1 with the key on the last byte.
	function automatic logic parse_flow_byte(input logic [7:0] b, input logic last,
			output flow_key_t key);
		int        p;
		int        offs;
		int        need;
		fke_cls_t  cls;
		logic [31:0] hi;
		logic [31:0] lo;
		p = int'(parser.pos);
		if (p == 0) parser.ihl = b[3:0];
		if (p == 1) parser.tos = b;
		if (p == 6 && b[5:0] != 6'd0) parser.frag = 1'b1;
		if (p == 7 && b != 8'd0) parser.frag = 1'b1;
		if (p == 9) parser.proto = b;
		if (p >= 12 && p < 16) parser.src = {parser.src[23:0], b};
		if (p >= 16 && p < 20) parser.dst = {parser.dst[23:0], b};
		offs = int'(parser.ihl) * 4;
		if (p >= offs && p < offs + int'(XPORT_MAX) && parser.xcount < XPORT_MAX) begin
			parser.xbytes = parser.xbytes | (64'(b) << (56 - 8 * int'(parser.xcount)));
			parser.xcount = parser.xcount + 4'd1;
		end
		if (parser.pos < POS_MAX) parser.pos = parser.pos + 7'd1;
		key = '0;
		if (!last) return 1'b0;

		cls  = CLS_NONE;
		need = 0;
		if (!parser.frag) begin
			case (parser.proto)
				PROTO_TCP, PROTO_UDP, PROTO_DCCP, PROTO_SCTP, PROTO_UDPLITE: begin
					cls  = CLS_PORTS;
					need = 4;
				end
				PROTO_ICMP: begin
					cls  = CLS_ICMP;
					need = 2;
				end
				PROTO_ESP: begin
					cls  = CLS_ESP;
					need = 4;
				end
				PROTO_AH: begin
					cls  = CLS_AH;
					need = 8;
				end
				PROTO_IPCOMP: begin
					cls  = CLS_IPCOMP;
					need = 4;
				end
				default: cls = CLS_NONE;
			endcase
		end
		hi = parser.xbytes[63:32];
		lo = parser.xbytes[31:0];
		if (int'(parser.xcount) >= need) begin
			case (cls)
				CLS_PORTS: begin
					key.src_port = hi[31:16];
					key.dst_port = hi[15:0];
				end
				CLS_ICMP: begin
					key.icmp_kind    = hi[31:24];
					key.icmp_subcode = hi[23:16];
				end
				CLS_ESP:    key.security_index = hi;
				CLS_AH:     key.security_index = lo;
				CLS_IPCOMP: key.security_index = {16'd0, hi[15:0]};
				default: ;
			endcase
		end
		key.protocol        = parser.proto;
		key.src_addr        = parser.src;
		key.dst_addr        = parser.dst;
		key.type_of_service = parser.tos;
		key.is_fragment     = parser.frag;
		key.too_short       = (parser.pos < HDR_MIN_BYTES) || (int'(parser.xcount) < need);
		parser = '0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			errors++;
		end
	endfunction

	function automatic logic [7:0] pick_proto(input int unsigned idx);
		case (idx)
			0: return PROTO_TCP;
			1: return PROTO_UDP;
			2: return PROTO_UDPLITE;
			3: return PROTO_SCTP;
			4: return PROTO_DCCP;
			5: return PROTO_ICMP;
			6: return PROTO_ESP;
			7: return PROTO_AH;
			default: return PROTO_IPCOMP;
		endcase
	endfunction

	function automatic void build_packet(input int ihl, input logic [7:0] tos,
			input logic [7:0] b6, input logic [7:0] b7, input logic [7:0] proto, input int len);
		pkt.delete();
		for (int i = 0; i < len; i++) begin
			case (i)
				0: pkt.push_back({4'($urandom_range(15)), 4'(ihl)});
				1: pkt.push_back(tos);
				6: pkt.push_back(b6);
				7: pkt.push_back(b7);
				9: pkt.push_back(proto);
				default: pkt.push_back(8'($urandom));
			endcase
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		flow_key_t key;
		while (!no_gaps && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
		if (parse_flow_byte(b, last, key)) pending_keys.push_back(key);
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++)
			send_byte(pkt[i], i == pkt.size() - 1);
		pkts_sent++;
	endtask

	// Well-formed packets dominate; the rest is noise with any header at all.
	task automatic send_random_packet(input bit well_formed);
		int         ihl;
		int         len;
		logic [7:0] b6;
		logic [7:0] b7;
		logic [7:0] proto;
		if (well_formed) begin
			ihl   = ($urandom_range(3) == 0) ? int'($urandom_range(15, 6)) : 5;
			proto = pick_proto($urandom_range(8));
			if ($urandom_range(99) < 10) begin
				b6 = 8'($urandom);
				b7 = 8'($urandom);
			end else begin
				b6 = {2'($urandom_range(3)), 6'd0};
				b7 = 8'd0;
			end
			if ($urandom_range(99) < 15) len = ihl * 4 + int'($urandom_range(7));
			else len = ihl * 4 + 8 + int'($urandom_range(6));
		end else begin
			ihl   = int'($urandom_range(15));
			proto = ($urandom_range(1) == 0) ? pick_proto($urandom_range(8)) : 8'($urandom);
			b6    = 8'($urandom);
			b7    = 8'($urandom);
			if ($urandom_range(99) < 5) len = int'($urandom_range(140, 128));
			else len = int'($urandom_range(48, 1));
		end
		build_packet(ihl, 8'($urandom), b6, b7, proto, len);
		send_packet();
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_keys.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_cases();
		build_packet(5, 8'hFF, 8'h00, 8'h00, PROTO_TCP, 28);     send_packet();
		build_packet(5, 8'h00, 8'h40, 8'h00, PROTO_UDP, 24);     send_packet();
		build_packet(5, 8'h5A, 8'h00, 8'h00, PROTO_UDPLITE, 24); send_packet();
		build_packet(5, 8'hA5, 8'h00, 8'h00, PROTO_SCTP, 24);    send_packet();
		build_packet(5, 8'h12, 8'h00, 8'h00, PROTO_DCCP, 25);    send_packet();
		build_packet(5, 8'h34, 8'h00, 8'h00, PROTO_ICMP, 22);    send_packet();
		build_packet(5, 8'h56, 8'h00, 8'h00, PROTO_ESP, 24);     send_packet();
		build_packet(5, 8'h78, 8'h00, 8'h00, PROTO_AH, 28);      send_packet();
		build_packet(5, 8'h9A, 8'h00, 8'h00, PROTO_IPCOMP, 24);  send_packet();
		build_packet(5, 8'hBC, 8'h00, 8'h00, 8'hFF, 30);         send_packet();
		// fragments: MF flag, then offset in the low byte only
		build_packet(5, 8'h01, 8'h20, 8'h00, PROTO_TCP, 28);     send_packet();
		build_packet(5, 8'h02, 8'h00, 8'h01, PROTO_UDP, 28);     send_packet();
		// reserved and DF bits alone are not a fragment
		build_packet(5, 8'h03, 8'hC0, 8'h00, PROTO_TCP, 28);     send_packet();
		// header cut short, then transport cut short
		build_packet(5, 8'h04, 8'h00, 8'h00, PROTO_TCP, 10);     send_packet();
		build_packet(5, 8'h05, 8'h00, 8'h00, PROTO_TCP, 22);     send_packet();
		build_packet(5, 8'h06, 8'h00, 8'h00, PROTO_AH, 27);      send_packet();
		// transport overlapping the fixed header, then the largest header length
		build_packet(0, 8'h07, 8'h00, 8'h00, PROTO_ICMP, 20);    send_packet();
		build_packet(2, 8'h08, 8'h00, 8'h00, PROTO_ESP, 24);     send_packet();
		build_packet(15, 8'h09, 8'h00, 8'h00, PROTO_TCP, 64);    send_packet();
		// runs past the position counter's ceiling, then a single byte, all ones and all zeros
		build_packet(5, 8'h0A, 8'h00, 8'h00, PROTO_UDP, 130);    send_packet();
		build_packet(5, 8'h0B, 8'h00, 8'h00, PROTO_UDP, 1);      send_packet();
		pkt.delete();
		repeat (24) pkt.push_back(8'hFF);
		send_packet();
		pkt.delete();
		repeat (24) pkt.push_back(8'h00);
		send_packet();
	endtask

	task automatic test_streaming();
		no_gaps = 1'b1;
		repeat (2) send_random_packet(1'b1);
		no_gaps = 1'b0;
	endtask

	// Sender runs flat out so that the queue fills well inside the hold-off.
	task automatic test_backpressure();
		no_gaps = 1'b1;
		holds_asked++;
		repeat (4) send_random_packet(1'b1);
		no_gaps = 1'b0;
	endtask

	task automatic test_random_traffic();
		int start_pkts;
		start_pkts = pkts_sent;
		while (bytes_sent < TOTAL_BYTES || pkts_sent - start_pkts < MIN_RAND_PKTS)
			send_random_packet($urandom_range(99) < 75);
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (holds_taken < holds_asked) begin
			holds_taken++;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_gaps && ($urandom_range(99) < 19);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_keys.size() == 0) begin
				$error("flow key transfer with none pending");
				errors++;
			end else begin
				got_key = pending_keys.pop_front();
				check_field("protocol", 32'(got_key.protocol), 32'(protocol));
				check_field("src_addr", got_key.src_addr, src_addr);
				check_field("dst_addr", got_key.dst_addr, dst_addr);
				check_field("type_of_service", 32'(got_key.type_of_service),
					32'(type_of_service));
				check_field("src_port", 32'(got_key.src_port), 32'(src_port));
				check_field("dst_port", 32'(got_key.dst_port), 32'(dst_port));
				check_field("icmp_kind", 32'(got_key.icmp_kind), 32'(icmp_kind));
				check_field("icmp_subcode", 32'(got_key.icmp_subcode), 32'(icmp_subcode));
				check_field("security_index", got_key.security_index, security_index);
				check_field("is_fragment", 32'(got_key.is_fragment), 32'(is_fragment));
				check_field("too_short", 32'(got_key.too_short), 32'(too_short));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		bytes_sent  = 0;
		pkts_sent   = 0;
		holds_asked = 0;
		no_gaps     = 1'b0;
		parser      = '0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= 8'd0;
		last_byte <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		wait_drain();
		test_streaming();
		wait_drain();
		test_backpressure();
		wait_drain();
		test_random_traffic();
		wait_drain();
		repeat (10) @(posedge clk);

		if (errors == 0 && pending_keys.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
design/fke_pkg.sv
design/fke_front.sv
design/fke_queue.sv
design/fke_back.sv
design/ipv4_flow_key_extract_core.sv
verif/ipv4_flow_key_extract_core_tb.sv
